// File: rtl/usb_control_request_responder_assert.svh
// Assertion macros used by the responder back end
`ifndef USB_CONTROL_REQUEST_RESPONDER_ASSERT_SVH
`define USB_CONTROL_REQUEST_RESPONDER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define UCRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ucrr assertion failed");

// next-cycle implication
`define UCRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ucrr assertion failed");

`endif

// File: rtl/ucrr_pkg.sv
// Types, codes and descriptor tables for the control request responder
`default_nettype none
package ucrr_pkg;

  localparam int MAX_PACKET_DEF = 64;
  localparam int LEN_W = 7;

  // event kinds
  localparam logic [1:0] ACT_SETUP = 2'd0;
  localparam logic [1:0] ACT_RESET = 2'd1;
  localparam logic [1:0] ACT_IN    = 2'd2;

  // reply kinds
  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_ACK    = 3'd1;
  localparam logic [2:0] KIND_STALL  = 3'd2;
  localparam logic [2:0] KIND_ADDR   = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  // link states
  localparam logic [1:0] LINK_DEFAULT    = 2'd0;
  localparam logic [1:0] LINK_ADDRESSED  = 2'd1;
  localparam logic [1:0] LINK_CONFIGURED = 2'd2;

  // request type selector (bits 6:5)
  localparam logic [1:0] SEL_STANDARD = 2'd0;
  localparam logic [1:0] SEL_CLASS    = 2'd1;

  // request codes
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
  localparam logic [7:0] REQ_SET_LINE_CODING   = 8'h20;
  localparam logic [7:0] REQ_GET_LINE_CODING   = 8'h21;
  localparam logic [7:0] REQ_SET_CTRL_LINE     = 8'h22;

  // descriptor types
  localparam logic [7:0] DT_DEVICE = 8'd1;
  localparam logic [7:0] DT_CONFIG = 8'd2;
  localparam logic [7:0] DT_STRING = 8'd3;

  // register indexes
  localparam logic [1:0] REG_LINE_RATE   = 2'd0;
  localparam logic [1:0] REG_STOP_FORMAT = 2'd1;
  localparam logic [1:0] REG_PARITY_MODE = 2'd2;
  localparam logic [1:0] REG_DATA_BITS   = 2'd3;

  localparam logic [23:0] LINE_RATE_RST = 24'd115200;
  localparam logic [4:0]  DATA_BITS_RST = 5'd8;

  // reply byte sources
  typedef enum logic [2:0] {
    SRC_DEV, SRC_CFG, SRC_LANG, SRC_MFR, SRC_PROD, SRC_SER, SRC_LC, SRC_CFGB
  } src_t;

  localparam logic [LEN_W-1:0] LEN_DEV  = 7'd18;
  localparam logic [LEN_W-1:0] LEN_CFG  = 7'd67;
  localparam logic [LEN_W-1:0] LEN_LANG = 7'd4;
  localparam logic [LEN_W-1:0] LEN_MFR  = 7'd18;
  localparam logic [LEN_W-1:0] LEN_PROD = 7'd20;
  localparam logic [LEN_W-1:0] LEN_SER  = 7'd22;
  localparam logic [LEN_W-1:0] LEN_LC   = 7'd7;
  localparam logic [LEN_W-1:0] LEN_ONE  = 7'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;
  } in_t;

  typedef struct packed {
    logic [2:0] reply_kind;
    logic [7:0] reply_byte;
    logic       last;
    logic [1:0] device_state;
    logic [6:0] bus_address;
    logic [7:0] config_number;
  } out_t;

  typedef struct packed {
    logic [2:0]       kind;
    src_t             src;
    logic [LEN_W-1:0] len;
    logic [1:0]       link;
    logic [6:0]       addr;
    logic [7:0]       cfg;
  } cmd_t;

  typedef struct packed {
    logic [23:0] line_rate;
    logic [1:0]  stop_format;
    logic [2:0]  parity_mode;
    logic [4:0]  data_bits;
  } lc_cfg_t;

  localparam logic [7:0] ROM_DEV [18] = '{
    8'd18, 8'h01, 8'h00, 8'h02, 8'h02, 8'h00, 8'h00, 8'd64,
    8'h83, 8'h04, 8'h40, 8'h57, 8'h00, 8'h02, 8'd1, 8'd2, 8'd3, 8'd1
  };

  localparam logic [7:0] ROM_CFG [67] = '{
    8'd9, 8'h02, 8'd67, 8'h00, 8'h02, 8'h01, 8'h00, 8'h80, 8'h32,
    8'd9, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h01, 8'h00,
    8'd5, 8'h24, 8'h00, 8'h10, 8'h01,
    8'd5, 8'h24, 8'h01, 8'h00, 8'h01,
    8'd4, 8'h24, 8'h02, 8'h02,
    8'd5, 8'h24, 8'h06, 8'h00, 8'h01,
    8'd7, 8'h05, 8'h82, 8'h03, 8'h08, 8'h00, 8'h10,
    8'd9, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0A, 8'h00, 8'h00, 8'h00,
    8'd7, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00,
    8'd7, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00
  };

  localparam logic [7:0] ROM_LANG [4] = '{8'd4, 8'h03, 8'h09, 8'h04};

  localparam logic [7:0] ROM_MFR [18] = '{
    8'd18, 8'h03, 8'h53, 8'h00, 8'h54, 8'h00, 8'h4D, 8'h00, 8'h69, 8'h00,
    8'h63, 8'h00, 8'h72, 8'h00, 8'h6F, 8'h00, 8'h73, 8'h00
  };

  localparam logic [7:0] ROM_PROD [20] = '{
    8'd20, 8'h03, 8'h53, 8'h00, 8'h54, 8'h00, 8'h4D, 8'h00, 8'h33, 8'h00,
    8'h32, 8'h00, 8'h20, 8'h00, 8'h56, 8'h00, 8'h43, 8'h00, 8'h50, 8'h00
  };

  localparam logic [7:0] ROM_SER [22] = '{
    8'd22, 8'h03, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00,
    8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00, 8'h30, 8'h00,
    8'h31, 8'h00
  };

  // descriptor byte lookup; an index at or past the descriptor length reads as zero
  function automatic logic [7:0] rom_byte(src_t src, logic [5:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (src)
      SRC_DEV:  if (idx < 6'd18) b = ROM_DEV[idx[4:0]];
      SRC_CFG:  b = ROM_CFG[{1'b0, idx}];
      SRC_LANG: if (idx < 6'd4) b = ROM_LANG[idx[1:0]];
      SRC_MFR:  if (idx < 6'd18) b = ROM_MFR[idx[4:0]];
      SRC_PROD: if (idx < 6'd20) b = ROM_PROD[idx[4:0]];
      SRC_SER:  if (idx < 6'd22) b = ROM_SER[idx[4:0]];
      default:  b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: rtl/usb_control_request_responder.sv
// Control endpoint request responder for a CDC serial function: each event
// word (setup, bus reset, IN complete) yields one or more result words. A
// data reply of n bytes leaves at one word per cycle, while the consumer pops
// them, once its command is loaded from the queue; the streamer takes the next
// command only after the last word of the current one. The decoder takes an
// event per cycle until its two-entry command queue fills. Line coding
// registers sit on the APB port at byte offsets 0, 4, 8 and 12.
`default_nettype none
module usb_control_request_responder #(
  parameter int MAX_PACKET = ucrr_pkg::MAX_PACKET_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_push,
  output logic                in_full,
  input  wire ucrr_pkg::in_t  in_word,
  output logic                out_empty,
  input  wire logic           out_pop,
  output ucrr_pkg::out_t      out_word,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  ucrr_pkg::lc_cfg_t lc_r;
  ucrr_pkg::cmd_t    f_cmd, q_cmd;
  logic              f_push, q_full, q_valid, q_pop;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      ucrr_pkg::REG_LINE_RATE:   prdata = {8'd0, lc_r.line_rate};
      ucrr_pkg::REG_STOP_FORMAT: prdata = {30'd0, lc_r.stop_format};
      ucrr_pkg::REG_PARITY_MODE: prdata = {29'd0, lc_r.parity_mode};
      default:                   prdata = {27'd0, lc_r.data_bits};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r.line_rate   <= ucrr_pkg::LINE_RATE_RST;
      lc_r.stop_format <= 2'd0;
      lc_r.parity_mode <= 3'd0;
      lc_r.data_bits   <= ucrr_pkg::DATA_BITS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ucrr_pkg::REG_LINE_RATE:   lc_r.line_rate   <= pwdata[23:0];
        ucrr_pkg::REG_STOP_FORMAT: lc_r.stop_format <= pwdata[1:0];
        ucrr_pkg::REG_PARITY_MODE: lc_r.parity_mode <= pwdata[2:0];
        default:                   lc_r.data_bits   <= pwdata[4:0];
      endcase
    end
  end

  ucrr_front #(.MAX_PACKET(MAX_PACKET)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_word  (in_word),
    .in_full  (in_full),
    .cmd_push (f_push),
    .cmd      (f_cmd),
    .cmd_full (q_full)
  );

  ucrr_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (f_push),
    .wr_cmd (f_cmd),
    .full   (q_full),
    .valid  (q_valid),
    .rd_cmd (q_cmd),
    .pop    (q_pop)
  );

  ucrr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .lc        (lc_r),
    .out_empty (out_empty),
    .out_word  (out_word),
    .out_pop   (out_pop)
  );

endmodule
`default_nettype wire

// File: rtl/ucrr_front.sv
// Front end: decodes events, tracks device state, issues reply commands
`default_nettype none
module ucrr_front #(
  parameter int MAX_PACKET = ucrr_pkg::MAX_PACKET_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  input  wire ucrr_pkg::in_t in_word,
  output logic               in_full,
  output logic               cmd_push,
  output ucrr_pkg::cmd_t     cmd,
  input  wire logic          cmd_full
);

  localparam logic [ucrr_pkg::LEN_W-1:0] MAXP = ucrr_pkg::LEN_W'(MAX_PACKET);

  logic [1:0] link_r, link_nxt;
  logic [6:0] pend_r, pend_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [7:0] cfg_r, cfg_nxt;

  logic                         accept;
  logic                         is_get;
  logic [2:0]                   kind;
  ucrr_pkg::src_t               src;
  logic [ucrr_pkg::LEN_W-1:0]   dlen;
  logic [ucrr_pkg::LEN_W-1:0]   n_w;
  logic [ucrr_pkg::LEN_W-1:0]   n_clamp;
  logic [1:0]                   sel;
  logic [7:0]                   new_cfg;

  assign in_full  = cmd_full;
  assign accept   = in_push && !cmd_full;
  assign sel      = in_word.request_type[6:5];
  assign new_cfg  = in_word.request_value[7:0];
  assign cmd_push = accept && (in_word.action == ucrr_pkg::ACT_SETUP ||
                               in_word.action == ucrr_pkg::ACT_RESET ||
                               in_word.action == ucrr_pkg::ACT_IN);

  always_comb begin
    link_nxt = link_r;
    pend_nxt = pend_r;
    addr_nxt = addr_r;
    cfg_nxt  = cfg_r;
    is_get   = 1'b0;
    kind     = ucrr_pkg::KIND_STALL;
    src      = ucrr_pkg::SRC_DEV;
    dlen     = ucrr_pkg::LEN_ONE;
    unique case (in_word.action)
      ucrr_pkg::ACT_SETUP: begin
        if (sel == ucrr_pkg::SEL_STANDARD) begin
          unique case (in_word.request_code)
            ucrr_pkg::REQ_GET_DESCRIPTOR: begin
              unique case (in_word.request_value[15:8])
                ucrr_pkg::DT_DEVICE: begin
                  is_get = 1'b1;
                  src    = ucrr_pkg::SRC_DEV;
                  dlen   = ucrr_pkg::LEN_DEV;
                end
                ucrr_pkg::DT_CONFIG: begin
                  is_get = 1'b1;
                  src    = ucrr_pkg::SRC_CFG;
                  dlen   = ucrr_pkg::LEN_CFG;
                end
                ucrr_pkg::DT_STRING: begin
                  is_get = (in_word.request_value[7:2] == 6'd0);
                  unique case (in_word.request_value[1:0])
                    2'd0: begin src = ucrr_pkg::SRC_LANG; dlen = ucrr_pkg::LEN_LANG; end
                    2'd1: begin src = ucrr_pkg::SRC_MFR;  dlen = ucrr_pkg::LEN_MFR;  end
                    2'd2: begin src = ucrr_pkg::SRC_PROD; dlen = ucrr_pkg::LEN_PROD; end
                    default: begin src = ucrr_pkg::SRC_SER; dlen = ucrr_pkg::LEN_SER; end
                  endcase
                end
                default: is_get = 1'b0;
              endcase
            end
            ucrr_pkg::REQ_SET_ADDRESS: begin
              pend_nxt = in_word.request_value[6:0];
              link_nxt = ucrr_pkg::LINK_ADDRESSED;
              kind     = ucrr_pkg::KIND_ACK;
            end
            ucrr_pkg::REQ_SET_CONFIGURATION: begin
              cfg_nxt = new_cfg;
              if (new_cfg == 8'd1) begin
                link_nxt = ucrr_pkg::LINK_CONFIGURED;
              end else if (new_cfg == 8'd0 && link_r == ucrr_pkg::LINK_CONFIGURED) begin
                link_nxt = ucrr_pkg::LINK_ADDRESSED;
              end
              kind = ucrr_pkg::KIND_ACK;
            end
            ucrr_pkg::REQ_GET_CONFIGURATION: begin
              is_get = 1'b1;
              src    = ucrr_pkg::SRC_CFGB;
              dlen   = ucrr_pkg::LEN_ONE;
            end
            default: kind = ucrr_pkg::KIND_STALL;
          endcase
        end else if (sel == ucrr_pkg::SEL_CLASS) begin
          unique case (in_word.request_code)
            ucrr_pkg::REQ_SET_LINE_CODING, ucrr_pkg::REQ_SET_CTRL_LINE:
              kind = ucrr_pkg::KIND_ACK;
            ucrr_pkg::REQ_GET_LINE_CODING: begin
              is_get = 1'b1;
              src    = ucrr_pkg::SRC_LC;
              dlen   = ucrr_pkg::LEN_LC;
            end
            default: kind = ucrr_pkg::KIND_STALL;
          endcase
        end
      end
      ucrr_pkg::ACT_RESET: begin
        link_nxt = ucrr_pkg::LINK_DEFAULT;
        pend_nxt = 7'd0;
        addr_nxt = 7'd0;
        cfg_nxt  = 8'd0;
        kind     = ucrr_pkg::KIND_STATUS;
      end
      ucrr_pkg::ACT_IN: begin
        if (pend_r != 7'd0 && link_r == ucrr_pkg::LINK_ADDRESSED) begin
          addr_nxt = pend_r;
          kind     = ucrr_pkg::KIND_ADDR;
        end else begin
          kind = ucrr_pkg::KIND_STATUS;
        end
      end
      default: kind = ucrr_pkg::KIND_STALL;
    endcase
  end

  // reply length = min(descriptor, wLength, max packet)
  always_comb begin
    if (in_word.request_length < 16'(dlen)) n_w = in_word.request_length[ucrr_pkg::LEN_W-1:0];
    else                                     n_w = dlen;
    n_clamp = (n_w > MAXP) ? MAXP : n_w;
  end

  always_comb begin
    cmd.kind = kind;
    cmd.src  = src;
    cmd.len  = ucrr_pkg::LEN_ONE;
    if (is_get) begin
      if (n_clamp == '0) begin
        cmd.kind = ucrr_pkg::KIND_STATUS;
      end else begin
        cmd.kind = ucrr_pkg::KIND_DATA;
        cmd.len  = n_clamp;
      end
    end
    cmd.link = link_nxt;
    cmd.addr = addr_nxt;
    cmd.cfg  = cfg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= ucrr_pkg::LINK_DEFAULT;
      pend_r <= 7'd0;
      addr_r <= 7'd0;
      cfg_r  <= 8'd0;
    end else if (cmd_push) begin
      link_r <= link_nxt;
      pend_r <= pend_nxt;
      addr_r <= addr_nxt;
      cfg_r  <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ucrr_cmdq.sv
// Two-entry command queue between the decoder and the reply streamer
`default_nettype none
module ucrr_cmdq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ucrr_pkg::cmd_t wr_cmd,
  output logic                full,
  output logic                valid,
  output ucrr_pkg::cmd_t      rd_cmd,
  input  wire logic           pop
);

  ucrr_pkg::cmd_t slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign rd_cmd  = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ucrr_back.sv
// Back end: streams each command's result words into the output register
`default_nettype none
module ucrr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire ucrr_pkg::cmd_t    q_cmd,
  output logic                   q_pop,
  input  wire ucrr_pkg::lc_cfg_t lc,
  output logic                   out_empty,
  output ucrr_pkg::out_t         out_word,
  input  wire logic              out_pop
);

  `include "usb_control_request_responder_assert.svh"

  ucrr_pkg::cmd_t             cmd_r;
  ucrr_pkg::out_t             out_r, out_nxt;
  logic                       busy_r, out_valid_r;
  logic [ucrr_pkg::LEN_W-1:0] idx_r;
  logic                       advance, emit, is_last;
  logic [7:0]                 byte_sel;

  assign advance   = !out_valid_r || out_pop;
  assign emit      = busy_r && advance;
  assign q_pop     = !busy_r && q_valid;
  assign is_last   = (idx_r == ucrr_pkg::LEN_W'(cmd_r.len - ucrr_pkg::LEN_ONE));
  assign out_empty = !out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    case (cmd_r.src)
      ucrr_pkg::SRC_LC: begin
        case (idx_r[2:0])
          3'd0:    byte_sel = lc.line_rate[7:0];
          3'd1:    byte_sel = lc.line_rate[15:8];
          3'd2:    byte_sel = lc.line_rate[23:16];
          3'd4:    byte_sel = {6'd0, lc.stop_format};
          3'd5:    byte_sel = {5'd0, lc.parity_mode};
          3'd6:    byte_sel = {3'd0, lc.data_bits};
          default: byte_sel = 8'h00;
        endcase
      end
      ucrr_pkg::SRC_CFGB: byte_sel = cmd_r.cfg;
      default:            byte_sel = ucrr_pkg::rom_byte(cmd_r.src, idx_r[5:0]);
    endcase
  end

  always_comb begin
    out_nxt.reply_kind    = cmd_r.kind;
    out_nxt.reply_byte    = (cmd_r.kind == ucrr_pkg::KIND_DATA) ? byte_sel : 8'h00;
    out_nxt.last          = is_last;
    out_nxt.device_state  = cmd_r.link;
    out_nxt.bus_address   = cmd_r.addr;
    out_nxt.config_number = cmd_r.cfg;
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
    if (emit)  out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (emit) begin
        idx_r <= idx_r + ucrr_pkg::LEN_ONE;
        if (is_last) busy_r <= 1'b0;
      end
      if (emit)         out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  // non-data replies are single words
  `UCRR_ASSERT_IMP(a_single_last, out_valid_r && out_r.reply_kind != ucrr_pkg::KIND_DATA, out_r.last)
  // streamer finishes after emitting the final word
  `UCRR_ASSERT_NXT(a_done_idle, emit && is_last, !busy_r)
  // a new command is only taken while the streamer is idle
  `UCRR_ASSERT_IMP(a_load_idle, q_pop, !busy_r)
  // index never passes the command length
  `UCRR_ASSERT_IMP(a_idx_range, busy_r, idx_r < cmd_r.len)

endmodule
`default_nettype wire

// File: verif/tb.sv
// Testbench for the control request responder: directed table, then random events
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int LIMIT = 400000;
  localparam int N_RAND = 104;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [7:0] RT_STD_IN = 8'h80;
  localparam logic [7:0] RT_STD_OUT = 8'h00;
  localparam logic [7:0] RT_CLS_IN = 8'hA1;
  localparam logic [7:0] RT_CLS_OUT = 8'h21;
  localparam logic [7:0] RT_VENDOR = 8'h40;
  localparam logic [7:0] RT_RESERVED = 8'h60;

  typedef struct {
    ucrr_pkg::in_t  w;
    bit             chk;
    ucrr_pkg::out_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  ucrr_pkg::in_t in_word = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  ucrr_pkg::out_t out_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  usb_control_request_responder u_top (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_word(in_word),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // descriptor images
  logic [7:0] dev_desc [18] = '{18, 8'h01, 8'h00, 8'h02, 8'h02, 8'h00, 8'h00, 64,
    8'h83, 8'h04, 8'h40, 8'h57, 8'h00, 8'h02, 1, 2, 3, 1};
  logic [7:0] cfg_desc [67] = '{9, 8'h02, 67, 8'h00, 8'h02, 8'h01, 8'h00, 8'h80, 8'h32,
    9, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h01, 8'h00,
    5, 8'h24, 8'h00, 8'h10, 8'h01, 5, 8'h24, 8'h01, 8'h00, 8'h01,
    4, 8'h24, 8'h02, 8'h02, 5, 8'h24, 8'h06, 8'h00, 8'h01,
    7, 8'h05, 8'h82, 8'h03, 8'h08, 8'h00, 8'h10,
    9, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0A, 8'h00, 8'h00, 8'h00,
    7, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00,
    7, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00};
  logic [7:0] lang_desc [4] = '{4, 8'h03, 8'h09, 8'h04};
  logic [7:0] mfr_desc [18] = '{18, 8'h03, 8'h53, 0, 8'h54, 0, 8'h4D, 0, 8'h69, 0,
    8'h63, 0, 8'h72, 0, 8'h6F, 0, 8'h73, 0};
  logic [7:0] prod_desc [20] = '{20, 8'h03, 8'h53, 0, 8'h54, 0, 8'h4D, 0, 8'h33, 0,
    8'h32, 0, 8'h20, 0, 8'h56, 0, 8'h43, 0, 8'h50, 0};
  logic [7:0] ser_desc [22] = '{22, 8'h03, 8'h30, 0, 8'h30, 0, 8'h30, 0, 8'h30, 0,
    8'h30, 0, 8'h30, 0, 8'h30, 0, 8'h30, 0, 8'h30, 0, 8'h31, 0};

  // device shadow state
  logic [1:0] link_q;
  logic [6:0] pend_addr_q, bus_addr_q;
  logic [7:0] cfg_num_q;
  logic [23:0] rate_q;
  logic [1:0] stop_q;
  logic [2:0] parity_q;
  logic [4:0] dbits_q;

  ucrr_pkg::out_t reply_q [$];
  int errors = 0;
  int cycles = 0;
  int hold_req = 0;

  function automatic void add_reply(logic [2:0] kind, logic [7:0] b, logic last);
    ucrr_pkg::out_t r;
    r.reply_kind = kind;
    r.reply_byte = b;
    r.last = last;
    r.device_state = link_q;
    r.bus_address = bus_addr_q;
    r.config_number = cfg_num_q;
    reply_q.push_back(r);
  endfunction

  function automatic void add_data(logic [7:0] bytes [67], int len, int wlen);
    int n;
    n = len;
    if (n > wlen) n = wlen;
    if (n > 64) n = 64;
    if (n == 0) add_reply(ucrr_pkg::KIND_STATUS, 8'h00, 1'b1);
    for (int i = 0; i < n; i++) add_reply(ucrr_pkg::KIND_DATA, bytes[i], i == n - 1);
  endfunction

  function automatic void respond(ucrr_pkg::in_t w);
    logic [7:0] buf8 [67];
    logic [1:0] sel;
    int wlen;
    foreach (buf8[i]) buf8[i] = 8'h00;
    sel = w.request_type[6:5];
    wlen = int'(w.request_length);
    if (w.action == ucrr_pkg::ACT_RESET) begin
      link_q = ucrr_pkg::LINK_DEFAULT;
      pend_addr_q = '0;
      bus_addr_q = '0;
      cfg_num_q = '0;
      add_reply(ucrr_pkg::KIND_STATUS, 8'h00, 1'b1);
    end else if (w.action == ucrr_pkg::ACT_IN) begin
      if (pend_addr_q != 7'd0 && link_q == ucrr_pkg::LINK_ADDRESSED) begin
        bus_addr_q = pend_addr_q;
        add_reply(ucrr_pkg::KIND_ADDR, 8'h00, 1'b1);
      end else add_reply(ucrr_pkg::KIND_STATUS, 8'h00, 1'b1);
    end else if (w.action == ucrr_pkg::ACT_SETUP) begin
      if (sel == ucrr_pkg::SEL_STANDARD && w.request_code == ucrr_pkg::REQ_GET_DESCRIPTOR) begin
        case (w.request_value[15:8])
          ucrr_pkg::DT_DEVICE: begin
            foreach (dev_desc[i]) buf8[i] = dev_desc[i];
            add_data(buf8, 18, wlen);
          end
          ucrr_pkg::DT_CONFIG: begin
            foreach (cfg_desc[i]) buf8[i] = cfg_desc[i];
            add_data(buf8, 67, wlen);
          end
          ucrr_pkg::DT_STRING: begin
            case (w.request_value[7:0])
              8'd0: begin
                foreach (lang_desc[i]) buf8[i] = lang_desc[i];
                add_data(buf8, 4, wlen);
              end
              8'd1: begin
                foreach (mfr_desc[i]) buf8[i] = mfr_desc[i];
                add_data(buf8, 18, wlen);
              end
              8'd2: begin
                foreach (prod_desc[i]) buf8[i] = prod_desc[i];
                add_data(buf8, 20, wlen);
              end
              8'd3: begin
                foreach (ser_desc[i]) buf8[i] = ser_desc[i];
                add_data(buf8, 22, wlen);
              end
              default: add_reply(ucrr_pkg::KIND_STALL, 8'h00, 1'b1);
            endcase
          end
          default: add_reply(ucrr_pkg::KIND_STALL, 8'h00, 1'b1);
        endcase
      end else if (sel == ucrr_pkg::SEL_STANDARD &&
                   w.request_code == ucrr_pkg::REQ_SET_ADDRESS) begin
        pend_addr_q = w.request_value[6:0];
        link_q = ucrr_pkg::LINK_ADDRESSED;
        add_reply(ucrr_pkg::KIND_ACK, 8'h00, 1'b1);
      end else if (sel == ucrr_pkg::SEL_STANDARD &&
                   w.request_code == ucrr_pkg::REQ_SET_CONFIGURATION) begin
        cfg_num_q = w.request_value[7:0];
        if (cfg_num_q == 8'd1) link_q = ucrr_pkg::LINK_CONFIGURED;
        else if (cfg_num_q == 8'd0 && link_q == ucrr_pkg::LINK_CONFIGURED)
          link_q = ucrr_pkg::LINK_ADDRESSED;
        add_reply(ucrr_pkg::KIND_ACK, 8'h00, 1'b1);
      end else if (sel == ucrr_pkg::SEL_STANDARD &&
                   w.request_code == ucrr_pkg::REQ_GET_CONFIGURATION) begin
        buf8[0] = cfg_num_q;
        add_data(buf8, 1, wlen);
      end else if (sel == ucrr_pkg::SEL_CLASS &&
                   (w.request_code == ucrr_pkg::REQ_SET_LINE_CODING ||
                    w.request_code == ucrr_pkg::REQ_SET_CTRL_LINE)) begin
        add_reply(ucrr_pkg::KIND_ACK, 8'h00, 1'b1);
      end else if (sel == ucrr_pkg::SEL_CLASS &&
                   w.request_code == ucrr_pkg::REQ_GET_LINE_CODING) begin
        buf8[0] = rate_q[7:0];
        buf8[1] = rate_q[15:8];
        buf8[2] = rate_q[23:16];
        buf8[4] = {6'd0, stop_q};
        buf8[5] = {5'd0, parity_q};
        buf8[6] = {3'd0, dbits_q};
        add_data(buf8, 7, wlen);
      end else add_reply(ucrr_pkg::KIND_STALL, 8'h00, 1'b1);
    end
  endfunction

  function automatic ucrr_pkg::in_t mk(logic [1:0] a, logic [7:0] t, logic [7:0] c,
                                       logic [15:0] v, logic [15:0] l);
    ucrr_pkg::in_t w;
    w.action = a;
    w.request_type = t;
    w.request_code = c;
    w.request_value = v;
    w.request_length = l;
    return w;
  endfunction

  function automatic ucrr_pkg::out_t ctl(logic [2:0] k, logic [7:0] b, logic [1:0] s,
                                         logic [6:0] a, logic [7:0] c);
    ucrr_pkg::out_t r;
    r.reply_kind = k;
    r.reply_byte = b;
    r.last = 1'b1;
    r.device_state = s;
    r.bus_address = a;
    r.config_number = c;
    return r;
  endfunction

  function automatic ucrr_pkg::in_t random_event();
    int pick;
    logic [15:0] wlen;
    pick = $urandom_range(0, 19);
    wlen = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
    case (pick)
      0, 1, 2: return mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR,
                         {8'($urandom_range(1, 3)), 8'($urandom_range(0, 4))}, wlen);
      3: return mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR,
                   16'($urandom), wlen);
      4, 5: return mk(ucrr_pkg::ACT_SETUP, RT_STD_OUT, ucrr_pkg::REQ_SET_ADDRESS,
                      16'($urandom), 16'd0);
      6, 7: return mk(ucrr_pkg::ACT_IN, 8'($urandom), 8'($urandom), 16'($urandom),
                      16'($urandom));
      8, 9: return mk(ucrr_pkg::ACT_SETUP, RT_STD_OUT, ucrr_pkg::REQ_SET_CONFIGURATION,
                      {8'($urandom), 8'($urandom_range(0, 2))}, 16'd0);
      10: return mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_CONFIGURATION,
                    16'($urandom), wlen);
      11, 12: return mk(ucrr_pkg::ACT_SETUP, RT_CLS_IN, ucrr_pkg::REQ_GET_LINE_CODING,
                        16'($urandom), wlen);
      13: return mk(ucrr_pkg::ACT_SETUP, RT_CLS_OUT,
                    $urandom_range(0, 1) ? ucrr_pkg::REQ_SET_LINE_CODING :
                                           ucrr_pkg::REQ_SET_CTRL_LINE,
                    16'($urandom), 16'($urandom));
      14: return mk(ucrr_pkg::ACT_RESET, 8'($urandom), 8'($urandom), 16'($urandom),
                    16'($urandom));
      default: return mk(2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom),
                         16'($urandom), 16'($urandom));
    endcase
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ucrr_pkg::REG_LINE_RATE:   rate_q = val[23:0];
      ucrr_pkg::REG_STOP_FORMAT: stop_q = val[1:0];
      ucrr_pkg::REG_PARITY_MODE: parity_q = val[2:0];
      default:                   dbits_q = val[4:0];
    endcase
  endtask

  task automatic set_line(logic [23:0] r, logic [1:0] s, logic [2:0] p, logic [4:0] d);
    wait (reply_q.size() == 0);
    repeat (80) @(posedge clk);
    reg_write(ucrr_pkg::REG_LINE_RATE, {8'd0, r});
    reg_write(ucrr_pkg::REG_STOP_FORMAT, {30'd0, s});
    reg_write(ucrr_pkg::REG_PARITY_MODE, {29'd0, p});
    reg_write(ucrr_pkg::REG_DATA_BITS, {27'd0, d});
  endtask

  // offer one word; returns after the edge that takes it, or after a random idle gap that ends a burst
  int burst_left = 0;
  task automatic send_word(ucrr_pkg::in_t w, bit chk, ucrr_pkg::out_t typed);
    in_word <= w;
    in_push <= 1'b1;
    @(negedge clk);
    while (in_full) @(negedge clk);
    @(posedge clk);
    respond(w);
    if (chk) begin
      void'(reply_q.pop_back());
      reply_q.push_back(typed);
    end
    if (burst_left > 0) burst_left--;
    else begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  row_t rows [$];
  task automatic row(ucrr_pkg::in_t w, bit chk = 1'b0, ucrr_pkg::out_t typed = '0);
    row_t r;
    r.w = w;
    r.chk = chk;
    r.res = typed;
    rows.push_back(r);
  endtask

  initial begin
    link_q = ucrr_pkg::LINK_DEFAULT;
    pend_addr_q = '0;
    bus_addr_q = '0;
    cfg_num_q = '0;
    rate_q = ucrr_pkg::LINE_RATE_RST;
    stop_q = '0;
    parity_q = '0;
    dbits_q = ucrr_pkg::DATA_BITS_RST;

    row(mk(ucrr_pkg::ACT_RESET, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF), 1,
        ctl(ucrr_pkg::KIND_STATUS, 8'd0, ucrr_pkg::LINK_DEFAULT, 7'd0, 8'd0));
    row(mk(ucrr_pkg::ACT_IN, 8'h00, 8'h00, 16'h0000, 16'h0000), 1,
        ctl(ucrr_pkg::KIND_STATUS, 8'd0, ucrr_pkg::LINK_DEFAULT, 7'd0, 8'd0));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, 16'h0100, 16'hFFFF));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, 16'h0200, 16'hFFFF));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, 16'h0200, 16'd9));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, 16'h0300, 16'd255));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, 16'h0301, 16'd255));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, 16'h0302, 16'd255));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, 16'h0303, 16'd255));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, 16'h0304, 16'd255), 1,
        ctl(ucrr_pkg::KIND_STALL, 8'd0, ucrr_pkg::LINK_DEFAULT, 7'd0, 8'd0));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, 16'hFF01, 16'd255), 1,
        ctl(ucrr_pkg::KIND_STALL, 8'd0, ucrr_pkg::LINK_DEFAULT, 7'd0, 8'd0));
    // zero wLength: status only
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_DESCRIPTOR, 16'h0100, 16'd0), 1,
        ctl(ucrr_pkg::KIND_STATUS, 8'd0, ucrr_pkg::LINK_DEFAULT, 7'd0, 8'd0));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_OUT, ucrr_pkg::REQ_SET_ADDRESS, 16'hFFFF, 16'd0), 1,
        ctl(ucrr_pkg::KIND_ACK, 8'd0, ucrr_pkg::LINK_ADDRESSED, 7'd0, 8'd0));
    row(mk(ucrr_pkg::ACT_IN, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF), 1,
        ctl(ucrr_pkg::KIND_ADDR, 8'd0, ucrr_pkg::LINK_ADDRESSED, 7'h7F, 8'd0));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_OUT, ucrr_pkg::REQ_SET_CONFIGURATION, 16'h0001, 16'd0),
        1, ctl(ucrr_pkg::KIND_ACK, 8'd0, ucrr_pkg::LINK_CONFIGURED, 7'h7F, 8'd1));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, ucrr_pkg::REQ_GET_CONFIGURATION, 16'h0000, 16'd1),
        1, ctl(ucrr_pkg::KIND_DATA, 8'd1, ucrr_pkg::LINK_CONFIGURED, 7'h7F, 8'd1));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_OUT, ucrr_pkg::REQ_SET_CONFIGURATION, 16'h0000, 16'd0),
        1, ctl(ucrr_pkg::KIND_ACK, 8'd0, ucrr_pkg::LINK_ADDRESSED, 7'h7F, 8'd0));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_OUT, ucrr_pkg::REQ_SET_CONFIGURATION, 16'hFFFF, 16'd0),
        1, ctl(ucrr_pkg::KIND_ACK, 8'd0, ucrr_pkg::LINK_ADDRESSED, 7'h7F, 8'hFF));
    row(mk(ucrr_pkg::ACT_SETUP, RT_CLS_OUT, ucrr_pkg::REQ_SET_LINE_CODING, 16'h0000, 16'd7));
    row(mk(ucrr_pkg::ACT_SETUP, RT_CLS_OUT, ucrr_pkg::REQ_SET_CTRL_LINE, 16'h0003, 16'd0));
    row(mk(ucrr_pkg::ACT_SETUP, RT_CLS_IN, ucrr_pkg::REQ_GET_LINE_CODING, 16'h0000, 16'hFFFF));
    row(mk(ucrr_pkg::ACT_SETUP, RT_CLS_IN, 8'hFF, 16'h0000, 16'd7));
    row(mk(ucrr_pkg::ACT_SETUP, RT_VENDOR, ucrr_pkg::REQ_GET_DESCRIPTOR, 16'h0100, 16'd18));
    row(mk(ucrr_pkg::ACT_SETUP, RT_RESERVED, ucrr_pkg::REQ_SET_ADDRESS, 16'h0005, 16'd0));
    row(mk(ucrr_pkg::ACT_SETUP, RT_STD_IN, 8'h00, 16'h0000, 16'd2));
    // unused action code: no reply
    row(mk(ACT_NONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send_word(rows[i].w, rows[i].chk, rows[i].res);

    in_push <= 1'b0;
    set_line(24'd12000000, 2'd2, 3'd4, 5'd16);
    for (int i = 0; i < N_RAND; i++) begin
      if (i == 20) hold_req = 1;
      if (i == 45) begin
        in_push <= 1'b0;
        wait (reply_q.size() == 0);
        @(posedge clk);
      end
      if (i == 60) begin
        in_push <= 1'b0;
        set_line(24'd0, 2'd0, 3'd0, 5'd5);
      end
      if (i == 95) begin
        in_push <= 1'b0;
        set_line(24'($urandom_range(0, 12000000)), 2'($urandom_range(0, 2)),
                 3'($urandom_range(0, 4)), 5'($urandom_range(5, 16)));
      end
      send_word(random_event(), 1'b0, '0);
    end
    in_push <= 1'b0;
    wait (reply_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && reply_q.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  // result side: bursts of free flow and random stalls, plus one long hold
  int mode_left = 0;
  bit stall_mode = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req == 1) begin
      hold_req = 2;
      hold_left = 400;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 120);
      stall_mode = $urandom_range(0, 1);
    end else mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else out_pop <= rst_n && (!stall_mode || $urandom_range(0, 2) == 0);
  end

  // words are stable from the falling edge until the edge that takes them
  ucrr_pkg::out_t want;
  always @(negedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (reply_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %p", out_word);
      end else begin
        want = reply_q.pop_front();
        if (out_word.reply_kind !== want.reply_kind || out_word.reply_byte !== want.reply_byte ||
            out_word.last !== want.last || out_word.device_state !== want.device_state ||
            out_word.bus_address !== want.bus_address ||
            out_word.config_number !== want.config_number) begin
          errors++;
          if (errors <= 10) $display("mismatch: exp %p got %p", want, out_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/ucrr_pkg.sv
rtl/ucrr_front.sv
rtl/ucrr_cmdq.sv
rtl/ucrr_back.sv
rtl/usb_control_request_responder.sv
verif/tb.sv
